### rtl/core/imhpq_pkg.sv
// Shared types and constants for the indexed min-heap priority queue.
// No dependencies.
`default_nettype none
package imhpq_pkg;
   localparam int HEAP_CAPACITY = 1024;
   localparam int NODE_COUNT    = 4096;
   localparam int PRIORITY_BITS = 32;
   localparam int POS_W   = $clog2(HEAP_CAPACITY);
   localparam int CNT_W   = $clog2(HEAP_CAPACITY + 1);
   localparam int NODE_W  = 12;
   localparam int NIDX_W  = $clog2(NODE_COUNT);
   localparam int PRIO_W  = 32;
   localparam int ENTRY_W = NODE_W + PRIORITY_BITS;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0, MODE_DECREASE = 2'd1, MODE_REMOVE = 2'd2, MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0, STAT_FULL = 2'd1, STAT_EMPTY = 2'd2, STAT_ABSENT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_LOOK, ST_LOOK2, ST_DECIDE, ST_ROOT, ST_ROOT2,
      ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_RD2, ST_DN_CMP, ST_DONE
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;
endpackage
`default_nettype wire

### rtl/core/imhpq_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module imhpq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 44
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/indexed_min_heap_priority_queue.sv
// Top level of the indexed min-heap priority queue: control sequencer,
// heap-entry memory and node-position memory. Uses imhpq_pkg, imhpq_ram.
//
// Usage:
//  - req_ channel (valid/ready) carries one word: mode, node_id, priority_req.
//  - rsp_ channel (valid/ready) returns one word per request.
//  - One request is worked at a time. A query steps through LOOK, LOOK2
//    and DONE; insert and decrease pass DECIDE and UP_CMP per heap level
//    climbed, remove-min DN_RD, DN_RD2 and DN_CMP per level descended. The
//    pace is set by the single read port of the heap memory (one access per
//    step).
//  - After reset the position map is swept to zero, one entry per cycle;
//    req_ready stays low throughout the sweep.
//  - The result sits in an output register; the next request is taken as
//    soon as work is done, even while rsp_valid waits for rsp_ready. A new
//    result is not written until the old one is taken; until then the
//    sequencer holds in its done state and req_ready stays low.
`default_nettype none
module indexed_min_heap_priority_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [11:0] req_node_id,
   input  wire logic [31:0] req_priority_req,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_removed_node,
   output logic [31:0]      rsp_removed_priority,
   output logic             rsp_is_present,
   output logic             rsp_heap_empty,
   output logic [1:0]       rsp_status
);
   localparam int PW = imhpq_pkg::POS_W;
   localparam int CW = imhpq_pkg::CNT_W;
   localparam int NW = imhpq_pkg::NIDX_W;
   localparam int PB = imhpq_pkg::PRIORITY_BITS;
   localparam int EW = imhpq_pkg::ENTRY_W;

   imhpq_pkg::state_type state_ff, state_in;

   // request registers
   imhpq_pkg::mode_type   mode_ff, mode_in;
   logic [11:0]           node_ff, node_in;
   logic [PB-1:0]         prio_ff, prio_in;
   // working registers
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [PW-1:0]         pos_ff, pos_in;     // position of moving entry
   imhpq_pkg::entry_type  cur_ff, cur_in;     // moving entry
   imhpq_pkg::entry_type  c1_ff, c1_in;       // first child on the way down
   logic [NW-1:0]         clr_ff, clr_in;
   // result being built
   logic                  rv_ff, rv_in;
   logic [11:0]           rn_ff, rn_in;
   logic [31:0]           rp_ff, rp_in;
   logic                  rpres_ff, rpres_in;
   imhpq_pkg::status_type rst_ff, rst_in;
   logic                  rdone_ff, rdone_in; // last entry already loaded into cur
   // output word register
   logic [11:0]           out_node_ff, out_node_in;
   logic [31:0]           out_prio_ff, out_prio_in;
   logic                  out_pres_ff, out_pres_in;
   logic                  out_empty_ff, out_empty_in;
   imhpq_pkg::status_type out_stat_ff, out_stat_in;

   // heap memory ports
   logic                  h_we;
   logic [PW-1:0]         h_wa, h_ra;
   logic [EW-1:0]         h_wd, h_rd;
   // position memory ports
   logic                  p_we;
   logic [NW-1:0]         p_wa, p_ra;
   logic [PW-1:0]         p_wd, p_rd;

   imhpq_ram #(.DEPTH(imhpq_pkg::HEAP_CAPACITY), .WIDTH(EW)) u_heap (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));

   imhpq_ram #(.DEPTH(imhpq_pkg::NODE_COUNT), .WIDTH(PW)) u_pos (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   imhpq_pkg::entry_type rd_e;
   assign rd_e = imhpq_pkg::entry_type'(h_rd);

   logic [PW-1:0] parent_pos;
   logic [CW:0]   c1_idx, c2_idx;
   assign parent_pos = PW'((pos_ff - PW'(1)) >> 1);
   assign c1_idx = (CW+1)'({pos_ff, 1'b1});
   assign c2_idx = (CW+1)'({pos_ff, 1'b1}) + (CW+1)'(1);

   // child pick on the way down: smaller child, right child on a tie
   logic                 pick2;
   imhpq_pkg::entry_type pe;
   logic [PW-1:0]        pp;
   assign pick2 = !(c2_idx >= (CW+1)'(cnt_ff) || c1_ff.prio < rd_e.prio);
   assign pe    = pick2 ? rd_e : c1_ff;
   assign pp    = pick2 ? c2_idx[PW-1:0] : c1_idx[PW-1:0];

   logic present;
   assign present = ({1'b0, p_rd} < cnt_ff) && (rd_e.node == node_ff);

   assign req_ready = (state_ff == imhpq_pkg::ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_removed_node     = out_node_ff;
   assign rsp_removed_priority = out_prio_ff;
   assign rsp_is_present       = out_pres_ff;
   assign rsp_heap_empty       = out_empty_ff;
   assign rsp_status           = out_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imhpq_pkg::ST_CLEAR;
         cnt_ff   <= '0;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         rdone_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         rdone_ff <= rdone_in;
      end
      mode_ff  <= mode_in;  node_ff <= node_in; prio_ff <= prio_in;
      pos_ff   <= pos_in;   cur_ff  <= cur_in;  c1_ff   <= c1_in;
      rn_ff    <= rn_in;    rp_ff   <= rp_in;   rpres_ff <= rpres_in;
      rst_ff   <= rst_in;
      out_node_ff  <= out_node_in;  out_prio_ff <= out_prio_in;
      out_pres_ff  <= out_pres_in;  out_stat_ff <= out_stat_in;
      out_empty_ff <= out_empty_in;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; node_in = node_ff; prio_in = prio_ff;
      cnt_in = cnt_ff; pos_in = pos_ff; cur_in = cur_ff; c1_in = c1_ff;
      clr_in = clr_ff;
      rv_in = rv_ff; rdone_in = rdone_ff;
      rn_in = rn_ff; rp_in = rp_ff; rpres_in = rpres_ff; rst_in = rst_ff;
      out_node_in = out_node_ff; out_prio_in = out_prio_ff;
      out_pres_in = out_pres_ff; out_stat_in = out_stat_ff;
      out_empty_in = out_empty_ff;
      h_we = 1'b0; h_wa = pos_ff; h_wd = cur_ff; h_ra = pos_ff;
      p_we = 1'b0; p_wa = cur_ff.node[NW-1:0]; p_wd = pos_ff;
      p_ra = node_ff[NW-1:0];
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         imhpq_pkg::ST_CLEAR: begin
            p_we = 1'b1; p_wa = clr_ff; p_wd = '0;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == NW'(imhpq_pkg::NODE_COUNT - 1)) state_in = imhpq_pkg::ST_IDLE;
         end
         imhpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in = imhpq_pkg::mode_type'(req_mode);
               node_in = req_node_id;
               prio_in = PB'(req_priority_req);
               rn_in = '0; rp_in = '0; rpres_in = 1'b0; rst_in = imhpq_pkg::STAT_OK;
               p_ra = req_node_id[NW-1:0];
               if (imhpq_pkg::mode_type'(req_mode) == imhpq_pkg::MODE_REMOVE) begin
                  pos_in = '0;
                  state_in = imhpq_pkg::ST_ROOT;
               end else begin
                  state_in = imhpq_pkg::ST_LOOK;
               end
            end
         end
         imhpq_pkg::ST_LOOK: begin
            h_ra = p_rd;   // position map read done; fetch entry
            pos_in = p_rd;
            state_in = imhpq_pkg::ST_LOOK2;
         end
         imhpq_pkg::ST_LOOK2: begin
            state_in = imhpq_pkg::ST_DONE;
            cur_in = rd_e;
            if (mode_ff == imhpq_pkg::MODE_QUERY) begin
               rpres_in = present;
            end else if (present) begin
               if (prio_ff < rd_e.prio) begin
                  cur_in.prio = prio_ff;
                  state_in = imhpq_pkg::ST_DECIDE;
               end
            end else if (mode_ff == imhpq_pkg::MODE_INSERT &&
                         cnt_ff < CW'(imhpq_pkg::HEAP_CAPACITY)) begin
               cur_in.node = node_ff;
               cur_in.prio = prio_ff;
               pos_in = cnt_ff[PW-1:0];
               cnt_in = cnt_ff + CW'(1);
               state_in = imhpq_pkg::ST_DECIDE;
            end else if (mode_ff == imhpq_pkg::MODE_INSERT) begin
               rst_in = imhpq_pkg::STAT_FULL;
            end else begin
               rst_in = imhpq_pkg::STAT_ABSENT;
            end
         end
         imhpq_pkg::ST_DECIDE: begin
            // sift up: cur sits (logically) at pos_ff
            if (pos_ff == '0) begin
               h_we = 1'b1; p_we = 1'b1;
               state_in = imhpq_pkg::ST_DONE;
            end else begin
               h_ra = parent_pos;
               state_in = imhpq_pkg::ST_UP_CMP;
            end
         end
         imhpq_pkg::ST_UP_CMP: begin
            if (rd_e.prio > cur_ff.prio) begin
               // parent moves down into pos
               h_we = 1'b1; h_wd = h_rd;
               p_we = 1'b1; p_wa = rd_e.node[NW-1:0];
               pos_in = parent_pos;
               state_in = imhpq_pkg::ST_DECIDE;
            end else begin
               h_we = 1'b1; p_we = 1'b1;
               state_in = imhpq_pkg::ST_DONE;
            end
         end
         imhpq_pkg::ST_ROOT: begin
            if (cnt_ff == '0) begin
               rst_in = imhpq_pkg::STAT_EMPTY;
               state_in = imhpq_pkg::ST_DONE;
            end else begin
               h_ra = '0;
               state_in = imhpq_pkg::ST_ROOT2;
            end
         end
         imhpq_pkg::ST_ROOT2: begin
            rn_in = rd_e.node;
            rp_in = 32'(rd_e.prio);
            cnt_in = cnt_ff - CW'(1);
            h_ra = PW'(cnt_ff - CW'(1));
            state_in = imhpq_pkg::ST_DN_RD;
         end
         imhpq_pkg::ST_DN_RD: begin
            // last entry arrives (first pass) or loop head
            if (pos_ff == '0 && rdone_ff == 1'b0) begin
               cur_in = rd_e;
               rdone_in = 1'b1;
            end
            if (c1_idx >= (CW+1)'(cnt_ff)) begin
               state_in = imhpq_pkg::ST_DONE;
               if (cnt_ff != '0) begin
                  h_we = 1'b1; p_we = 1'b1;
                  if (rdone_ff == 1'b0) begin
                     h_wd = h_rd; p_wa = rd_e.node[NW-1:0];
                  end
               end
               rdone_in = 1'b0;
            end else begin
               h_ra = c1_idx[PW-1:0];
               state_in = imhpq_pkg::ST_DN_RD2;
            end
         end
         imhpq_pkg::ST_DN_RD2: begin
            c1_in = rd_e;
            h_ra = c2_idx[PW-1:0];
            state_in = imhpq_pkg::ST_DN_CMP;
         end
         imhpq_pkg::ST_DN_CMP: begin
            if (pe.prio < cur_ff.prio) begin
               h_we = 1'b1; h_wd = pe;
               p_we = 1'b1; p_wa = pe.node[NW-1:0];
               pos_in = pp;
               state_in = imhpq_pkg::ST_DN_RD;
            end else begin
               h_we = 1'b1; p_we = 1'b1;
               rdone_in = 1'b0;
               state_in = imhpq_pkg::ST_DONE;
            end
         end
         imhpq_pkg::ST_DONE: begin
            rdone_in = 1'b0;
            // hand the word over once the output register is free
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               out_node_in  = rn_ff;
               out_prio_in  = rp_ff;
               out_pres_in  = rpres_ff;
               out_stat_in  = rst_ff;
               out_empty_in = (cnt_ff == '0);
               state_in = imhpq_pkg::ST_IDLE;
            end
         end
         default: state_in = imhpq_pkg::ST_IDLE;
      endcase
   end

   // no word accepted during the clearing sweep
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == imhpq_pkg::ST_CLEAR |-> !req_ready)
      else $error("request accepted while clearing");
   // count never exceeds capacity
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(imhpq_pkg::HEAP_CAPACITY))
      else $error("entry count overflow");
   // a raised result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(out_node_ff) && $stable(out_stat_ff)
         && $stable(out_empty_ff) && $stable(out_prio_ff))
      else $error("result dropped");
endmodule
`default_nettype wire
